FILE: rtl/ffha_pkg.sv
// Package for the first-fit heap allocator: sizes, codes, block table entry,
// request and response words, sequencer states. No dependencies.
package ffha_pkg;

    localparam int MAX_BLOCKS    = 64;
    localparam int HEADER_BYTES  = 16;
    localparam int PAGE_BYTES    = 4096;
    localparam int MIN_BLOCK     = HEADER_BYTES + 4;
    localparam int IDX_W         = $clog2(MAX_BLOCKS);
    localparam int CNT_W         = IDX_W + 1;
    localparam int PAGE_SHIFT    = $clog2(PAGE_BYTES);

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_FREE    = 2'd1;
    localparam logic [1:0] ACT_REALLOC = 2'd2;
    localparam logic [1:0] ACT_INIT    = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OOM     = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_DOUBLE  = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_LIMIT = 2'd1;
    localparam logic [1:0] REG_PAGES = 2'd2;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] size;
        logic        is_free;
    } entry_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [24:0] request_bytes;
        logic [31:0] address;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] result_address;
        logic [24:0] copy_bytes;
        logic [31:0] total_bytes;
        logic [31:0] used_bytes;
        logic [31:0] free_bytes;
    } result_t;

    typedef struct packed {
        logic [31:0] heap_base;
        logic [31:0] heap_limit;
        logic [12:0] initial_pages;
    } cfg_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_FIT_RD, S_FIT_CHK, S_FIND_RD, S_FIND_CHK,
        S_GROW, S_GROW_CHK, S_SPLIT, S_SHIFT_RD, S_SHIFT_WR, S_SPLIT_WR,
        S_SPLIT_WR2, S_COAL_RD, S_COAL_CHK, S_RESP
    } state_t;

    function automatic logic [31:0] block_need(input logic [24:0] req);
        logic [31:0] n;
        n = 32'(req) + 32'(HEADER_BYTES);
        if (n < 32'(MIN_BLOCK))
        begin
            n = 32'(MIN_BLOCK);
        end
        return (n + 32'd3) & ~32'd3;
    endfunction

endpackage

FILE: rtl/ffha_if.sv
// Request and response channel interfaces of the heap allocator.
// Valid/ready handshake; no package dependency.
interface ffha_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [24:0] request_bytes;
    logic [31:0] address;
    modport source(output valid, action, request_bytes, address, input ready);
    modport sink(input valid, action, request_bytes, address, output ready);
endinterface

interface ffha_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] result_address;
    logic [24:0] copy_bytes;
    logic [31:0] total_bytes;
    logic [31:0] used_bytes;
    logic [31:0] free_bytes;
    modport source(output valid, status, result_address, copy_bytes, total_bytes,
                   used_bytes, free_bytes, input ready);
    modport sink(input valid, status, result_address, copy_bytes, total_bytes,
                 used_bytes, free_bytes, output ready);
endinterface

FILE: rtl/first_fit_heap_allocator.sv
// The steps a request takes depend on its path: a free of address zero is the
// shortest; others scan the live blocks of the table (up to 64) and a free adds
// a coalescing pass; a split also moves the entries above it, read then written.
// The block table memory has one read and one write port; a scan reads an entry
// in one state and checks it in the next. One request is in work at a time; a
// finished word waits in the output register while the next request is taken.
module first_fit_heap_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ffha_req_if.sink    req,
    ffha_rsp_if.source  rsp
);
    import ffha_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    result_t out_reg;
    result_t core_res;
    logic    out_valid_reg, out_valid_next;
    logic    core_idle, core_done, out_free, wr_en;
    cmd_t    cmd;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_BASE:  cfg_next.heap_base = pwdata;
                REG_LIMIT: cfg_next.heap_limit = pwdata;
                REG_PAGES: cfg_next.initial_pages = pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_BASE:  prdata = cfg_reg.heap_base;
            REG_LIMIT: prdata = cfg_reg.heap_limit;
            REG_PAGES: prdata = {19'd0, cfg_reg.initial_pages};
            default:   prdata = '0;
        endcase
    end

    assign cmd = '{action: req.action, request_bytes: req.request_bytes,
                   address: req.address};
    assign req.ready = core_idle;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign out_valid_next = core_done || (out_valid_reg && !rsp.ready);

    ffha_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .start    (req.valid && core_idle),
        .cmd      (cmd),
        .idle     (core_idle),
        .out_free (out_free),
        .done     (core_done),
        .res      (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.heap_base     <= 32'h0040_0000;
            cfg_reg.heap_limit    <= 32'h0100_0000;
            cfg_reg.initial_pages <= 13'd16;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_done)
        begin
            out_reg <= core_res;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.result_address = out_reg.result_address;
    assign rsp.copy_bytes     = out_reg.copy_bytes;
    assign rsp.total_bytes    = out_reg.total_bytes;
    assign rsp.used_bytes     = out_reg.used_bytes;
    assign rsp.free_bytes     = out_reg.free_bytes;

endmodule

FILE: rtl/ffha_core.sv
// Allocator sequencer: block table memory, scan/grow/split/coalesce steps.
// Depends on ffha_pkg.
module ffha_core (
    input  logic             clk,
    input  logic             rst_n,
    input  ffha_pkg::cfg_t   cfg,
    input  logic             start,
    input  ffha_pkg::cmd_t   cmd,
    output logic             idle,
    input  logic             out_free,
    output logic             done,
    output ffha_pkg::result_t res
);
    import ffha_pkg::*;

    entry_t mem [MAX_BLOCKS];
    entry_t rdata;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] w_reg, w_next;
    logic [IDX_W-1:0] cur_idx_reg, cur_idx_next;
    entry_t cur_reg, cur_next;
    entry_t pent_reg, pent_next;
    logic [31:0] top_reg, top_next, total_reg, total_next;
    logic [31:0] used_reg, used_next, freec_reg, freec_next;
    logic [31:0] need_reg, need_next;
    logic [32:0] gbytes_reg, gbytes_next;
    logic        galloc_reg, galloc_next;
    logic        ffree_reg, ffree_next;
    logic        pend_reg, pend_next;
    cmd_t        cmd_reg, cmd_next;
    logic [2:0]  st_reg, st_next;
    logic [31:0] raddr_reg, raddr_next;
    logic [24:0] copy_reg, copy_next;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    entry_t           wdata;

    logic [31:0] hdr, payload;
    logic [32:0] grow_sum;
    logic        scan_end, fit_hit, find_hit, grow_oom, tbl_full, split_ok;
    logic        req_fits, merge, shift_needed;
    logic [CNT_W-1:0] last_idx;

    assign hdr      = cmd_reg.address - 32'(HEADER_BYTES);
    assign payload  = rdata.size - 32'(HEADER_BYTES);
    assign scan_end = idx_reg == cnt_reg;
    assign fit_hit  = rdata.is_free && (rdata.size >= need_reg);
    assign find_hit = rdata.start == hdr;
    assign grow_sum = {1'b0, top_reg} + gbytes_reg;
    assign grow_oom = grow_sum > {1'b0, cfg.heap_limit};
    assign tbl_full = cnt_reg == CNT_W'(MAX_BLOCKS);
    assign split_ok = ({1'b0, cur_reg.size} >= ({1'b0, need_reg} + 33'(MIN_BLOCK)))
                      && !tbl_full;
    assign req_fits = 32'(cmd_reg.request_bytes) <= payload;
    assign merge    = (cnt_reg != '0) && rdata.is_free;
    assign last_idx = cnt_reg - 1'b1;
    assign shift_needed = last_idx > CNT_W'(cur_idx_reg);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (start) state_next = S_DECODE;
            S_DECODE:
            begin
                if (cmd_reg.action == ACT_INIT)
                    state_next = S_GROW;
                else if (cmd_reg.action == ACT_ALLOC
                         || (cmd_reg.action == ACT_REALLOC && cmd_reg.address == '0))
                    state_next = S_FIT_RD;
                else if ((cmd_reg.action == ACT_FREE || cmd_reg.request_bytes == '0)
                         && cmd_reg.address == '0)
                    state_next = S_RESP;
                else
                    state_next = S_FIND_RD;
            end
            S_FIT_RD:   state_next = scan_end ? S_GROW : S_FIT_CHK;
            S_FIT_CHK:  state_next = fit_hit ? S_SPLIT : S_FIT_RD;
            S_FIND_RD:  state_next = scan_end ? S_RESP : S_FIND_CHK;
            S_FIND_CHK:
            begin
                if (!find_hit)
                    state_next = S_FIND_RD;
                else if (rdata.is_free)
                    state_next = S_RESP;
                else if (ffree_reg)
                    state_next = S_COAL_RD;
                else if (req_fits)
                    state_next = S_RESP;
                else
                    state_next = S_FIT_RD;
            end
            S_GROW:
            begin
                if (grow_oom || gbytes_reg == '0)
                    state_next = S_RESP;
                else
                    state_next = S_GROW_CHK;
            end
            S_GROW_CHK:
            begin
                if (!merge && tbl_full)
                    state_next = S_RESP;
                else
                    state_next = galloc_reg ? S_SPLIT : S_RESP;
            end
            S_SPLIT:
            begin
                if (split_ok)
                    state_next = shift_needed ? S_SHIFT_RD : S_SPLIT_WR;
                else
                    state_next = pend_reg ? S_FIND_RD : S_RESP;
            end
            S_SHIFT_RD: state_next = S_SHIFT_WR;
            S_SHIFT_WR:
                state_next = (idx_reg == CNT_W'(cur_idx_reg) + 1'b1) ? S_SPLIT_WR : S_SHIFT_RD;
            S_SPLIT_WR: state_next = S_SPLIT_WR2;
            S_SPLIT_WR2: state_next = pend_reg ? S_FIND_RD : S_RESP;
            S_COAL_RD:  state_next = scan_end ? S_RESP : S_COAL_CHK;
            S_COAL_CHK: state_next = S_COAL_RD;
            S_RESP:     if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = rdata;
        raddr = idx_reg[IDX_W-1:0];
        idle  = state_reg == S_IDLE;
        done  = (state_reg == S_RESP) && out_free;
        unique case (state_reg)
            S_GROW:     raddr = last_idx[IDX_W-1:0];
            S_FIND_CHK:
            begin
                if (find_hit && !rdata.is_free && ffree_reg)
                begin
                    we = 1'b1;
                    waddr = idx_reg[IDX_W-1:0];
                    wdata = '{start: rdata.start, size: rdata.size, is_free: 1'b1};
                end
            end
            S_GROW_CHK:
            begin
                if (merge)
                begin
                    we = 1'b1;
                    waddr = last_idx[IDX_W-1:0];
                    wdata = '{start: rdata.start, size: rdata.size + gbytes_reg[31:0],
                              is_free: 1'b1};
                end
                else if (!tbl_full)
                begin
                    we = 1'b1;
                    waddr = cnt_reg[IDX_W-1:0];
                    wdata = '{start: top_reg, size: gbytes_reg[31:0], is_free: 1'b1};
                end
            end
            S_SPLIT:
            begin
                if (!split_ok)
                begin
                    we = 1'b1;
                    waddr = cur_idx_reg;
                    wdata = '{start: cur_reg.start, size: cur_reg.size, is_free: 1'b0};
                end
            end
            S_SHIFT_WR:
            begin
                we = 1'b1;
                waddr = idx_reg[IDX_W-1:0] + 1'b1;
            end
            S_SPLIT_WR:
            begin
                we = 1'b1;
                waddr = cur_idx_reg + 1'b1;
                wdata = '{start: cur_reg.start + need_reg, size: cur_reg.size - need_reg,
                          is_free: 1'b1};
            end
            S_SPLIT_WR2:
            begin
                we = 1'b1;
                waddr = cur_idx_reg;
                wdata = '{start: cur_reg.start, size: need_reg, is_free: 1'b0};
            end
            S_COAL_CHK:
            begin
                we = 1'b1;
                if ((w_reg != '0) && pent_reg.is_free && rdata.is_free)
                begin
                    waddr = w_reg[IDX_W-1:0] - 1'b1;
                    wdata = '{start: pent_reg.start, size: pent_reg.size + rdata.size,
                              is_free: 1'b1};
                end
                else
                begin
                    waddr = w_reg[IDX_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg; cnt_next = cnt_reg; w_next = w_reg;
        cur_idx_next = cur_idx_reg; cur_next = cur_reg; pent_next = pent_reg;
        top_next = top_reg; total_next = total_reg; used_next = used_reg;
        freec_next = freec_reg; need_next = need_reg; gbytes_next = gbytes_reg;
        galloc_next = galloc_reg; ffree_next = ffree_reg; pend_next = pend_reg;
        cmd_next = cmd_reg; st_next = st_reg; raddr_next = raddr_reg; copy_next = copy_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    st_next = ST_OK;
                    raddr_next = '0;
                    copy_next = '0;
                    pend_next = 1'b0;
                end
            end
            S_DECODE:
            begin
                idx_next = '0;
                need_next = block_need(cmd_reg.request_bytes);
                ffree_next = (cmd_reg.action == ACT_FREE) || (cmd_reg.request_bytes == '0);
                if (cmd_reg.action == ACT_INIT)
                begin
                    cnt_next = '0;
                    top_next = cfg.heap_base;
                    total_next = '0;
                    used_next = '0;
                    freec_next = '0;
                    gbytes_next = 33'(cfg.initial_pages) << PAGE_SHIFT;
                    galloc_next = 1'b0;
                end
            end
            S_FIT_RD:
            begin
                if (scan_end)
                begin
                    gbytes_next = ({1'b0, need_reg} + 33'(PAGE_BYTES - 1))
                                  & ~33'(PAGE_BYTES - 1);
                    galloc_next = 1'b1;
                end
            end
            S_FIT_CHK:
            begin
                if (fit_hit)
                begin
                    cur_next = rdata;
                    cur_idx_next = idx_reg[IDX_W-1:0];
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_FIND_RD:  if (scan_end) st_next = ST_INVALID;
            S_FIND_CHK:
            begin
                if (!find_hit)
                    idx_next = idx_reg + 1'b1;
                else if (rdata.is_free)
                    st_next = ST_DOUBLE;
                else if (ffree_reg)
                begin
                    used_next = used_reg - rdata.size;
                    freec_next = freec_reg + rdata.size;
                    idx_next = '0;
                    w_next = '0;
                end
                else if (req_fits)
                    raddr_next = cmd_reg.address;
                else
                begin
                    copy_next = payload[24:0];
                    pend_next = 1'b1;
                    idx_next = '0;
                end
            end
            S_GROW:     if (grow_oom) st_next = ST_OOM;
            S_GROW_CHK:
            begin
                if (merge)
                begin
                    cur_next = '{start: rdata.start, size: rdata.size + gbytes_reg[31:0],
                                 is_free: 1'b1};
                    cur_idx_next = last_idx[IDX_W-1:0];
                end
                else if (!tbl_full)
                begin
                    cur_next = '{start: top_reg, size: gbytes_reg[31:0], is_free: 1'b1};
                    cur_idx_next = cnt_reg[IDX_W-1:0];
                    cnt_next = cnt_reg + 1'b1;
                end
                if (!merge && tbl_full)
                    st_next = ST_FULL;
                else
                begin
                    top_next = top_reg + gbytes_reg[31:0];
                    total_next = total_reg + gbytes_reg[31:0];
                    freec_next = freec_reg + gbytes_reg[31:0];
                end
            end
            S_SPLIT:
            begin
                idx_next = last_idx;
                if (!split_ok)
                begin
                    used_next = used_reg + cur_reg.size;
                    freec_next = freec_reg - cur_reg.size;
                    raddr_next = cur_reg.start + 32'(HEADER_BYTES);
                    ffree_next = 1'b1;
                    idx_next = '0;
                end
            end
            S_SHIFT_WR: idx_next = idx_reg - 1'b1;
            S_SPLIT_WR: cnt_next = cnt_reg + 1'b1;
            S_SPLIT_WR2:
            begin
                used_next = used_reg + need_reg;
                freec_next = freec_reg + 32'(HEADER_BYTES) - need_reg;
                raddr_next = cur_reg.start + 32'(HEADER_BYTES);
                ffree_next = 1'b1;
                idx_next = '0;
            end
            S_COAL_RD:  if (scan_end) cnt_next = w_reg;
            S_COAL_CHK:
            begin
                if ((w_reg != '0) && pent_reg.is_free && rdata.is_free)
                    pent_next.size = pent_reg.size + rdata.size;
                else
                begin
                    pent_next = rdata;
                    w_next = w_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            top_reg   <= '0;
            total_reg <= '0;
            used_reg  <= '0;
            freec_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            top_reg   <= top_next;
            total_reg <= total_next;
            used_reg  <= used_next;
            freec_reg <= freec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next; w_reg <= w_next; cur_idx_reg <= cur_idx_next;
        cur_reg <= cur_next; pent_reg <= pent_next; need_reg <= need_next;
        gbytes_reg <= gbytes_next; galloc_reg <= galloc_next; ffree_reg <= ffree_next;
        pend_reg <= pend_next; cmd_reg <= cmd_next; st_reg <= st_next;
        raddr_reg <= raddr_next; copy_reg <= copy_next;
    end

    always_comb
    begin
        res.status         = st_reg;
        res.result_address = (st_reg == ST_OK) ? raddr_reg : '0;
        res.copy_bytes     = (st_reg == ST_OK) ? copy_reg : '0;
        res.total_bytes    = total_reg;
        res.used_bytes     = used_reg;
        res.free_bytes     = freec_reg;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count above table depth");
    a_wr_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> ({1'b0, waddr} <= cnt_reg))
        else $error("table write beyond live entries");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == S_IDLE)
        else $error("request taken while busy");
    a_done_ret: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> state_reg == S_IDLE)
        else $error("sequencer did not return to idle");

endmodule

FILE: bench/tb_first_fit_heap_allocator.sv
// Testbench for first_fit_heap_allocator: random and directed heap requests,
// checked word by word against a behavioral model of the block table.
// Depends on rtl/ffha_pkg.sv, rtl/ffha_if.sv and the allocator RTL.
module tb_first_fit_heap_allocator;
    import ffha_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ffha_req_if req_ch();
    ffha_rsp_if rsp_ch();

    first_fit_heap_allocator i_dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req(req_ch.sink), .rsp(rsp_ch.source)
    );

    // model state
    logic [31:0] m_base, m_limit;
    logic [12:0] m_pages;
    logic [31:0] tbl_start [MAX_BLOCKS];
    logic [31:0] tbl_size [MAX_BLOCKS];
    logic        tbl_free [MAX_BLOCKS];
    int          tbl_cnt;
    logic [31:0] top, total_cnt, used_cnt, free_cnt;

    cmd_t    pending_cmds[$];
    result_t expected_words[$];
    logic [31:0] live_addrs[$];
    int      errors;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_cycles;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [2:0] heap_grow(input logic [63:0] pages);
        logic [63:0] bytes;
        bytes = pages * PAGE_BYTES;
        if (64'(top) + bytes > 64'(m_limit))
        begin
            return ST_OOM;
        end
        if (bytes == 0)
        begin
            return ST_OK;
        end
        if (tbl_cnt > 0 && tbl_free[tbl_cnt-1])
        begin
            tbl_size[tbl_cnt-1] += bytes[31:0];
        end
        else
        begin
            if (tbl_cnt >= MAX_BLOCKS)
            begin
                return ST_FULL;
            end
            tbl_start[tbl_cnt] = top;
            tbl_size[tbl_cnt] = bytes[31:0];
            tbl_free[tbl_cnt] = 1'b1;
            tbl_cnt++;
        end
        top += bytes[31:0];
        total_cnt += bytes[31:0];
        free_cnt += bytes[31:0];
        return ST_OK;
    endfunction

    function automatic int first_fit(input logic [31:0] need);
        for (int i = 0; i < tbl_cnt; i++)
        begin
            if (tbl_free[i] && tbl_size[i] >= need)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic int block_at(input logic [31:0] addr);
        logic [31:0] hdr;
        hdr = addr - HEADER_BYTES;
        for (int i = 0; i < tbl_cnt; i++)
        begin
            if (tbl_start[i] == hdr)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic logic [2:0] heap_alloc(input logic [24:0] nbytes,
                                              output logic [31:0] addr);
        logic [31:0] need;
        logic [2:0]  st;
        int          idx;
        need = 32'(nbytes) + HEADER_BYTES;
        if (need < MIN_BLOCK)
        begin
            need = MIN_BLOCK;
        end
        need = (need + 3) & ~32'd3;
        addr = 0;
        idx = first_fit(need);
        if (idx < 0)
        begin
            st = heap_grow((64'(need) + PAGE_BYTES - 1) / PAGE_BYTES);
            if (st != ST_OK)
            begin
                return st;
            end
            idx = first_fit(need);
            if (idx < 0)
            begin
                return ST_OOM;
            end
        end
        if (64'(tbl_size[idx]) >= 64'(need) + MIN_BLOCK && tbl_cnt < MAX_BLOCKS)
        begin
            for (int j = tbl_cnt; j > idx + 1; j--)
            begin
                tbl_start[j] = tbl_start[j-1];
                tbl_size[j] = tbl_size[j-1];
                tbl_free[j] = tbl_free[j-1];
            end
            tbl_start[idx+1] = tbl_start[idx] + need;
            tbl_size[idx+1] = tbl_size[idx] - need;
            tbl_free[idx+1] = 1'b1;
            tbl_size[idx] = need;
            tbl_cnt++;
            free_cnt += HEADER_BYTES;
        end
        tbl_free[idx] = 1'b0;
        used_cnt += tbl_size[idx];
        free_cnt -= tbl_size[idx];
        addr = tbl_start[idx] + HEADER_BYTES;
        return ST_OK;
    endfunction

    function automatic logic [2:0] heap_release(input logic [31:0] addr);
        int idx;
        int w;
        if (addr == 0)
        begin
            return ST_OK;
        end
        idx = block_at(addr);
        if (idx < 0)
        begin
            return ST_INVALID;
        end
        if (tbl_free[idx])
        begin
            return ST_DOUBLE;
        end
        tbl_free[idx] = 1'b1;
        used_cnt -= tbl_size[idx];
        free_cnt += tbl_size[idx];
        w = 0;
        for (int r = 0; r < tbl_cnt; r++)
        begin
            if (w > 0 && tbl_free[w-1] && tbl_free[r])
            begin
                tbl_size[w-1] += tbl_size[r];
            end
            else
            begin
                tbl_start[w] = tbl_start[r];
                tbl_size[w] = tbl_size[r];
                tbl_free[w] = tbl_free[r];
                w++;
            end
        end
        tbl_cnt = w;
        return ST_OK;
    endfunction

    function automatic result_t heap_predict(input cmd_t c);
        result_t     res;
        logic [2:0]  st;
        logic [31:0] addr;
        logic [31:0] copy;
        logic [31:0] payload;
        int          idx;
        st = ST_OK;
        addr = 0;
        copy = 0;
        case (c.action)
            ACT_ALLOC: st = heap_alloc(c.request_bytes, addr);
            ACT_FREE: st = heap_release(c.address);
            ACT_REALLOC:
            begin
                if (c.address == 0)
                begin
                    st = heap_alloc(c.request_bytes, addr);
                end
                else if (c.request_bytes == 0)
                begin
                    st = heap_release(c.address);
                end
                else
                begin
                    idx = block_at(c.address);
                    if (idx < 0)
                    begin
                        st = ST_INVALID;
                    end
                    else if (tbl_free[idx])
                    begin
                        st = ST_DOUBLE;
                    end
                    else
                    begin
                        payload = tbl_size[idx] - HEADER_BYTES;
                        if (32'(c.request_bytes) <= payload)
                        begin
                            addr = c.address;
                        end
                        else
                        begin
                            st = heap_alloc(c.request_bytes, addr);
                            if (st == ST_OK)
                            begin
                                copy = payload;
                                void'(heap_release(c.address));
                            end
                        end
                    end
                end
            end
            default:
            begin
                tbl_cnt = 0;
                top = m_base;
                total_cnt = 0;
                used_cnt = 0;
                free_cnt = 0;
                st = heap_grow(64'(m_pages));
            end
        endcase
        if (st != ST_OK)
        begin
            addr = 0;
            copy = 0;
        end
        res.status = st;
        res.result_address = addr;
        res.copy_bytes = copy[24:0];
        res.total_bytes = total_cnt;
        res.used_bytes = used_cnt;
        res.free_bytes = free_cnt;
        return res;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.action <= '0;
            req_ch.request_bytes <= '0;
            req_ch.address <= '0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cmd_t c;
                c = pending_cmds.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.action <= c.action;
                req_ch.request_bytes <= c.request_bytes;
                req_ch.address <= c.address;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // predict on acceptance
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            cmd_t c;
            result_t r;
            c.action = req_ch.action;
            c.request_bytes = req_ch.request_bytes;
            c.address = req_ch.address;
            r = heap_predict(c);
            expected_words.push_back(r);
            if (r.result_address != 0)
            begin
                live_addrs.push_back(r.result_address);
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            result_t got;
            result_t want;
            got.status = rsp_ch.status;
            got.result_address = rsp_ch.result_address;
            got.copy_bytes = rsp_ch.copy_bytes;
            got.total_bytes = rsp_ch.total_bytes;
            got.used_bytes = rsp_ch.used_bytes;
            got.free_bytes = rsp_ch.free_bytes;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (got.status !== want.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                    errors++;
                end
                if (got.result_address !== want.result_address)
                begin
                    $display("%0t: address exp %h got %h", $time,
                             want.result_address, got.result_address);
                    errors++;
                end
                if (got.copy_bytes !== want.copy_bytes)
                begin
                    $display("%0t: copy exp %0d got %0d", $time,
                             want.copy_bytes, got.copy_bytes);
                    errors++;
                end
                if (got.total_bytes !== want.total_bytes)
                begin
                    $display("%0t: total exp %h got %h", $time,
                             want.total_bytes, got.total_bytes);
                    errors++;
                end
                if (got.used_bytes !== want.used_bytes)
                begin
                    $display("%0t: used exp %h got %h", $time,
                             want.used_bytes, got.used_bytes);
                    errors++;
                end
                if (got.free_bytes !== want.free_bytes)
                begin
                    $display("%0t: free exp %h got %h", $time,
                             want.free_bytes, got.free_bytes);
                    errors++;
                end
            end
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_BASE: m_base = val;
            REG_LIMIT: m_limit = val;
            default: m_pages = val[12:0];
        endcase
    endtask

    task automatic add_cmd(input logic [1:0] act, input logic [24:0] nbytes,
                           input logic [31:0] addr);
        cmd_t c;
        c.action = act;
        c.request_bytes = nbytes;
        c.address = addr;
        pending_cmds.push_back(c);
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || req_ch.valid || expected_words.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (400) @(posedge clk);
    endtask

    // mostly small sizes, occasionally large; addresses mostly live blocks
    task automatic add_random(input int n);
        logic [24:0] nb;
        logic [31:0] ad;
        int k;
        int sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            k = $urandom_range(9);
            nb = (k < 7) ? 25'($urandom_range(300)) :
                 (k < 9) ? 25'($urandom_range(20000)) : 25'($urandom);
            if (live_addrs.size() > 0 && $urandom_range(9) < 8)
            begin
                ad = live_addrs[$urandom_range(live_addrs.size() - 1)];
            end
            else
            begin
                ad = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
            end
            if (sel < 45)
            begin
                add_cmd(ACT_ALLOC, nb, 0);
            end
            else if (sel < 75)
            begin
                add_cmd(ACT_FREE, 0, ad);
            end
            else if (sel < 98)
            begin
                add_cmd(ACT_REALLOC, ($urandom_range(7) == 0) ? 25'd0 : nb, ad);
            end
            else
            begin
                add_cmd(ACT_INIT, 0, 0);
            end
            // keep the live list tracking what the model has issued
            if (pending_cmds.size() > 4)
            begin
                while (pending_cmds.size() > 4)
                begin
                    @(posedge clk);
                end
            end
        end
    endtask

    task automatic set_idle(input int s, input int r);
        send_idle_pct = s;
        recv_stall_pct = r;
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        hold_cycles = 0;
        m_base = 32'h0040_0000;
        m_limit = 32'h0100_0000;
        m_pages = 13'd16;
        tbl_cnt = 0;
        top = 0;
        total_cnt = 0;
        used_cnt = 0;
        free_cnt = 0;
        set_idle(0, 0);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // use before initialize, then directed cases
        add_cmd(ACT_ALLOC, 25'd0, 0);
        add_cmd(ACT_FREE, 0, 0);
        add_cmd(ACT_FREE, 0, 32'h1234);
        add_cmd(ACT_INIT, 0, 0);
        add_cmd(ACT_ALLOC, 25'd1, 0);
        add_cmd(ACT_ALLOC, 25'd4, 0);
        add_cmd(ACT_ALLOC, 25'd5000, 0);
        add_cmd(ACT_ALLOC, 25'h1FF_FFFF, 0);
        add_cmd(ACT_ALLOC, 25'd16777216, 0);
        add_cmd(ACT_FREE, 0, 32'h0040_0010);
        add_cmd(ACT_FREE, 0, 32'h0040_0010);
        add_cmd(ACT_FREE, 0, 32'hFFFF_FFFF);
        add_cmd(ACT_REALLOC, 25'd8, 0);
        add_cmd(ACT_REALLOC, 25'd2, 32'h0040_0010);
        add_cmd(ACT_REALLOC, 25'd4, 32'h0040_0024);
        add_cmd(ACT_REALLOC, 25'd9000, 32'h0040_0024);
        add_cmd(ACT_REALLOC, 25'd0, 32'h0040_0038);
        add_cmd(ACT_REALLOC, 25'd50, 32'h0000_0010);
        drain();

        // table full: many tiny blocks, then grow from a tight heap
        reg_write(REG_PAGES, 32'd1);
        reg_write(REG_LIMIT, 32'h0040_2000);
        add_cmd(ACT_INIT, 0, 0);
        for (int i = 0; i < 70; i++)
        begin
            add_cmd(ACT_ALLOC, 25'd4, 0);
        end
        add_cmd(ACT_ALLOC, 25'd10000, 0);
        drain();

        // extremes of the registers
        reg_write(REG_BASE, 32'hFFFF_F000);
        reg_write(REG_LIMIT, 32'hFFFF_FFFF);
        reg_write(REG_PAGES, 32'd4096);
        add_cmd(ACT_INIT, 0, 0);
        add_cmd(ACT_ALLOC, 25'd1, 0);
        drain();
        reg_write(REG_PAGES, 32'd0);
        add_cmd(ACT_INIT, 0, 0);
        drain();
        reg_write(REG_BASE, 32'd0);
        reg_write(REG_LIMIT, 32'd0);
        add_cmd(ACT_INIT, 0, 0);
        add_cmd(ACT_ALLOC, 25'd3, 0);
        drain();

        reg_write(REG_BASE, 32'h0001_0000);
        reg_write(REG_LIMIT, 32'h0020_0000);
        reg_write(REG_PAGES, 32'd4);
        add_cmd(ACT_INIT, 0, 0);
        add_random(300);
        drain();

        set_idle(52, 0);
        reg_write(REG_BASE, 32'h8000_0000);
        reg_write(REG_LIMIT, 32'h8004_0000);
        reg_write(REG_PAGES, 32'd2);
        add_cmd(ACT_INIT, 0, 0);
        add_random(300);
        drain();

        set_idle(0, 52);
        reg_write(REG_BASE, 32'h0040_0000);
        reg_write(REG_LIMIT, 32'h0100_0000);
        reg_write(REG_PAGES, 32'd16);
        add_cmd(ACT_INIT, 0, 0);
        add_random(300);
        drain();

        set_idle(37, 37);
        add_random(300);

        // long receiver hold while requests keep coming
        set_idle(0, 0);
        hold_cycles = 3000;
        add_random(60);
        drain();

        if (errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    initial
    begin
        #8000000;
        $display("tb: failure");
        $finish;
    end

endmodule
